[src/lbc_pkg.sv]
// Shared types and constants for the line buffer with cursor.
package lbc_pkg;

  localparam int LINE_MAX = 128;
  localparam int CNT_W    = $clog2(LINE_MAX + 1);
  localparam int CHAR_W   = 8;
  localparam int OUT_W    = 8;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [2:0] {
    REQ_LEFT   = 3'd0,
    REQ_RIGHT  = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_ERASE  = 3'd3,
    REQ_CHANGE = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_BOUNDARY = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Per-cycle command to one stack of cells
  typedef enum logic [1:0] {
    STK_HOLD = 2'd0,
    STK_PUSH = 2'd1,
    STK_POP  = 2'd2,
    STK_LOAD = 2'd3
  } stk_op_t;

  typedef struct packed {
    stk_op_t op;
    char_t   data;
  } stk_ctl_t;

  typedef struct packed {
    status_t          status;
    logic [OUT_W-1:0] cursor_pos;
    logic [OUT_W-1:0] line_length;
    char_t            char_at_cursor;
    logic             at_end;
  } res_t;

endpackage

[src/lbc_if.sv]
// Handshake interfaces for the request and result channels.
interface lbc_in_if;
  import lbc_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       req_type;
  logic [CHAR_W-1:0] char_value;

  modport source (output valid, req_type, char_value, input ready);
  modport sink   (input valid, req_type, char_value, output ready);
endinterface

interface lbc_out_if;
  import lbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [OUT_W-1:0]  cursor_pos;
  logic [OUT_W-1:0]  line_length;
  logic [CHAR_W-1:0] char_at_cursor;
  logic              at_end;

  modport source (output valid, status, cursor_pos, line_length, char_at_cursor, at_end,
                  input ready);
  modport sink   (input valid, status, cursor_pos, line_length, char_at_cursor, at_end,
                  output ready);
endinterface

[src/line_buffer_with_cursor.sv]
// Line buffer with cursor: top level with two cell stacks, decode and output buffering.
// The result of an accepted request is registered in out_r, via the skid word if out_ch is stalled.
// Throughput: one request per cycle while the skid word is empty; every cell shifts in parallel.
// A two-word result buffer lets one more request in while a result waits to be taken.
// Reset (synchronous, rst_n low): cursor and length go to zero, result buffer empties.
// Character cells are not cleared; only cells holding live characters are ever read.
module line_buffer_with_cursor import lbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lbc_in_if.sink    in_ch,
  lbc_out_if.source out_ch
);

  // The line is held as two stacks split at the cursor:
  //   left stack  - characters before the cursor, top is the one just left of it
  //   right stack - characters from the cursor on, top is the one under it
  // Moves pop one stack and push the other; insert pushes left; erase pops right;
  // change overwrites the right top, or acts as insert past the end. No indexed access to the line is ever needed.

  cnt_t     cur_r, cur_nxt;   // cursor = size of left stack
  cnt_t     cnt_r, cnt_nxt;   // line length
  stk_ctl_t lctl, rctl;
  char_t    left_head, left_head_nxt, right_head, right_head_nxt;
  status_t  status;
  logic     do_ins;
  logic     acc;
  res_t     res;

  // result buffer: main register plus skid word
  res_t     out_r, out_nxt;
  res_t     skid_r, skid_nxt;
  logic     out_v_r, out_v_nxt;
  logic     skid_v_r, skid_v_nxt;

  assign in_ch.ready = !skid_v_r;
  assign acc         = in_ch.valid && in_ch.ready;

  // ---------------- request decode ----------------
  always_comb begin
    status  = ST_BOUNDARY;
    cur_nxt = cur_r;
    cnt_nxt = cnt_r;
    do_ins  = 1'b0;
    lctl    = '{op: STK_HOLD, data: '0};
    rctl    = '{op: STK_HOLD, data: '0};

    case (req_t'(in_ch.req_type))
      REQ_LEFT: begin
        if (cur_r != '0) begin
          status  = ST_DONE;
          cur_nxt = cur_r - CNT_W'(1);
          lctl.op = STK_POP;
          rctl    = '{op: STK_PUSH, data: left_head};
        end
      end
      REQ_RIGHT: begin
        if (cur_r < cnt_r) begin
          status  = ST_DONE;
          cur_nxt = cur_r + CNT_W'(1);
          rctl.op = STK_POP;
          lctl    = '{op: STK_PUSH, data: right_head};
        end
      end
      REQ_INSERT: begin
        do_ins = 1'b1;
      end
      REQ_ERASE: begin
        // cursor index stays: it now names the following character or the end
        if (cur_r < cnt_r) begin
          status  = ST_DONE;
          cnt_nxt = cnt_r - CNT_W'(1);
          rctl.op = STK_POP;
        end
      end
      REQ_CHANGE: begin
        if (cur_r < cnt_r) begin
          status = ST_DONE;
          rctl   = '{op: STK_LOAD, data: in_ch.char_value};
        end else begin
          do_ins = 1'b1;   // past the end: acts as insert
        end
      end
      default: begin
        status = ST_BOUNDARY;  // unknown codes are ignored
      end
    endcase

    if (do_ins) begin
      if (cnt_r >= CNT_W'(LINE_MAX)) begin
        status = ST_FULL;      // character dropped
      end else begin
        status  = ST_DONE;
        cur_nxt = cur_r + CNT_W'(1);
        cnt_nxt = cnt_r + CNT_W'(1);
        lctl    = '{op: STK_PUSH, data: in_ch.char_value};
      end
    end

    // stacks move only on an accepted word
    if (!acc) begin
      lctl.op = STK_HOLD;
      rctl.op = STK_HOLD;
    end
  end

  lbc_stack u_left (
    .clk        (clk),
    .ctl        (lctl),
    .head_o     (left_head),
    .head_nxt_o (left_head_nxt)
  );

  lbc_stack u_right (
    .clk        (clk),
    .ctl        (rctl),
    .head_o     (right_head),
    .head_nxt_o (right_head_nxt)
  );

  // result word, taken from the post-update state
  always_comb begin
    res.status         = status;
    res.cursor_pos     = OUT_W'(cur_nxt);
    res.line_length    = OUT_W'(cnt_nxt);
    res.at_end         = (cur_nxt >= cnt_nxt);
    res.char_at_cursor = res.at_end ? '0 : right_head_nxt;
  end

  // ---------------- result buffer ----------------
  always_comb begin
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r) begin
      if (acc) begin
        out_nxt   = res;
        out_v_nxt = 1'b1;
      end
    end else if (out_ch.ready) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else if (acc) begin
        out_nxt = res;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (acc) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (acc) begin
        cur_r <= cur_nxt;
        cnt_r <= cnt_nxt;
      end
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.cursor_pos     = out_r.cursor_pos;
  assign out_ch.line_length    = out_r.line_length;
  assign out_ch.char_at_cursor = out_r.char_at_cursor;
  assign out_ch.at_end         = out_r.at_end;

  // ---------------- assertions ----------------
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LINE_MAX))
    else $error("line length beyond capacity");

  a_cur_len: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= cnt_r)
    else $error("cursor beyond line end");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held with empty output register");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && do_ins && status == ST_DONE) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not grow the line");

  a_ins_head: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && do_ins && status == ST_DONE) |-> (left_head_nxt == in_ch.char_value))
    else $error("inserted character not left of the cursor");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && status == ST_FULL) |=> ($stable(cnt_r) && $stable(cur_r)))
    else $error("dropped character changed the line");

endmodule

[src/lbc_cell.sv]
// One character cell of a stack chain.
module lbc_cell import lbc_pkg::*; (
  input  logic    clk,
  input  stk_op_t op,
  input  char_t   push_in,
  input  char_t   pop_in,
  output char_t   data_o,
  output char_t   data_nxt_o
);

  char_t data_r, data_nxt;

  always_comb begin
    case (op)
      STK_PUSH: data_nxt = push_in;
      STK_POP:  data_nxt = pop_in;
      STK_LOAD: data_nxt = push_in;
      STK_HOLD: data_nxt = data_r;
      default:  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o     = data_r;
  assign data_nxt_o = data_nxt;

endmodule

[src/lbc_stack.sv]
// Stack of LINE_MAX cells; cell 0 is the top, every cell shifts with its neighbors.
module lbc_stack import lbc_pkg::*; (
  input  logic     clk,
  input  stk_ctl_t ctl,
  output char_t    head_o,
  output char_t    head_nxt_o
);

  char_t   cell_q [LINE_MAX];
  stk_op_t cell_op [LINE_MAX];

  for (genvar i = 0; i < LINE_MAX; i++) begin : g_cell
    char_t push_w, pop_w, nxt_w;

    // Load only touches the top cell
    if (i == 0) begin : g_head
      assign cell_op[i] = ctl.op;
      assign push_w     = ctl.data;
      assign head_nxt_o = nxt_w;
    end else begin : g_body
      assign cell_op[i] = (ctl.op == STK_LOAD) ? STK_HOLD : ctl.op;
      assign push_w     = cell_q[i-1];
    end

    if (i == LINE_MAX - 1) begin : g_tail
      assign pop_w = '0;
    end else begin : g_mid
      assign pop_w = cell_q[i+1];
    end

    lbc_cell u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .push_in    (push_w),
      .pop_in     (pop_w),
      .data_o     (cell_q[i]),
      .data_nxt_o (nxt_w)
    );
  end

  assign head_o = cell_q[0];

endmodule
